// ===== rtl/delpr_pkg.sv =====
`default_nettype none
package delpr_pkg;

   localparam int SENSOR_CHANNELS_DEF = 14;
   localparam int BUTTON_CHANNELS_DEF = 3;
   localparam int SENSOR_TABLE_LEN    = 32;
   localparam int BUTTON_TABLE_LEN    = 16;

   localparam int SENSOR_Q_W  = 16;
   localparam int BUTTON_Q_W  = 20;
   localparam int PIN_W       = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 20;

   localparam logic [SENSOR_Q_W-1:0] SENSOR_DEBOUNCE_RST = SENSOR_Q_W'(50);
   localparam logic [BUTTON_Q_W-1:0] BUTTON_DEBOUNCE_RST = BUTTON_Q_W'(100000);
   localparam logic [PIN_W-1:0]      NO_PIN              = 8'hFF;

   localparam logic ACTION_TICK = 1'b0;
   localparam logic ACTION_READ = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SENSOR_DEBOUNCE = 2'd0,
      CSR_BUTTON_DEBOUNCE = 2'd1
   } csr_index_type;

   typedef logic [PIN_W-1:0] pin_type;

   // entries past the board's wiring read as pin 0
   localparam pin_type SENSOR_PIN_TABLE [SENSOR_TABLE_LEN] = '{
      8'd4, 8'd5, 8'd18, 8'd32, 8'd13, 8'd14, 8'd15, 8'd16,
      8'd17, 8'd25, 8'd23, 8'd26, 8'd27, 8'd33, 8'd0, 8'd0,
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
   };

   localparam pin_type BUTTON_PIN_TABLE [BUTTON_TABLE_LEN] = '{
      8'd19, 8'd0, 8'd12, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
   };

   typedef struct packed {
      logic    hit;
      pin_type pin;
   } pick_type;

endpackage
`default_nettype wire

// ===== rtl/debounced_event_latch_priority_read_core.sv =====
// Debounced event latch with priority read-out. Each request beat is either a sample tick
// (action 0), carrying one level per sensor and button input, or a read (action 1). Every
// channel has its own lane with a saturating quiet counter: a sensor change counts only once
// more than sensor_debounce ticks have passed since the last counted change, a low arms the
// channel and a following high latches an event; a button latches an event when a low reading
// has held for more than button_debounce ticks. A read returns one response beat with the pin
// number of the lowest pending sensor, else the lowest pending button, and clears it; with
// nothing pending it returns pin 255 and state 0. Ticks give no response. The block takes one
// beat per cycle while req_stall is low: the lanes update as the priority merge decides, and the
// response register holds a read result while the next beat enters. req_stall rises only when
// that register is full and rsp_stall is high. Write the two debounce registers while idle.
`default_nettype none
module debounced_event_latch_priority_read_core
   import delpr_pkg::*;
#(
   parameter int SENSOR_CHANNELS = SENSOR_CHANNELS_DEF,
   parameter int BUTTON_CHANNELS = BUTTON_CHANNELS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,

   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic                       req_action,
   input  wire logic [SENSOR_CHANNELS-1:0] req_sensor_levels,
   input  wire logic [BUTTON_CHANNELS-1:0] req_button_levels,

   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [PIN_W-1:0]                rsp_pin_number,
   output logic                            rsp_pin_state,

   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [CSR_DATA_W-1:0]      csr_data
);

   logic [SENSOR_Q_W-1:0]      sensor_debounce_ff;
   logic [BUTTON_Q_W-1:0]      button_debounce_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   pick_type                   rsp_pick_ff;
   logic                       accept;
   logic                       tick;
   logic                       read;
   logic [SENSOR_CHANNELS-1:0] sensor_pending;
   logic [BUTTON_CHANNELS-1:0] button_pending;
   logic [SENSOR_CHANNELS-1:0] sensor_grant;
   logic [BUTTON_CHANNELS-1:0] button_grant;
   pick_type                   pick;

   assign csr_ready = 1'b1;
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign tick      = accept && (req_action == ACTION_TICK);
   assign read      = accept && (req_action == ACTION_READ);

   always_ff @(posedge clock) begin
      if (reset) begin
         sensor_debounce_ff <= SENSOR_DEBOUNCE_RST;
         button_debounce_ff <= BUTTON_DEBOUNCE_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SENSOR_DEBOUNCE: sensor_debounce_ff <= csr_data[SENSOR_Q_W-1:0];
            CSR_BUTTON_DEBOUNCE: button_debounce_ff <= csr_data[BUTTON_Q_W-1:0];
            default: ;
         endcase
      end
   end

   for (genvar s = 0; s < SENSOR_CHANNELS; s++) begin : g_sensor
      delpr_sensor_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .tick     (tick),
         .level    (req_sensor_levels[s]),
         .debounce (sensor_debounce_ff),
         .clear    (read && sensor_grant[s]),
         .pending  (sensor_pending[s])
      );
   end

   for (genvar b = 0; b < BUTTON_CHANNELS; b++) begin : g_button
      delpr_button_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .tick     (tick),
         .reading  (req_button_levels[b]),
         .debounce (button_debounce_ff),
         .clear    (read && button_grant[b]),
         .pending  (button_pending[b])
      );
   end

   delpr_merge #(
      .SENSOR_CHANNELS (SENSOR_CHANNELS),
      .BUTTON_CHANNELS (BUTTON_CHANNELS)
   ) u_merge (
      .sensor_pending (sensor_pending),
      .button_pending (button_pending),
      .sensor_grant   (sensor_grant),
      .button_grant   (button_grant),
      .pick           (pick)
   );

   // hold the response beat until taken
   always_comb begin
      if (read) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (read) begin
         rsp_pick_ff <= pick;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pin_number = rsp_pick_ff.pin;
   assign rsp_pin_state  = rsp_pick_ff.hit;

endmodule
`default_nettype wire

// ===== rtl/delpr_sensor_lane.sv =====
`default_nettype none
module delpr_sensor_lane
   import delpr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  tick,
   input  wire logic                  level,
   input  wire logic [SENSOR_Q_W-1:0] debounce,
   input  wire logic                  clear,
   output logic                       pending
);

   logic                  prev_ff, prev_in;
   logic                  armed_ff, armed_in;
   logic                  pending_ff, pending_in;
   logic [SENSOR_Q_W-1:0] quiet_ff, quiet_in;
   logic [SENSOR_Q_W-1:0] quiet_inc;
   logic                  take;

   always_comb begin
      quiet_inc  = (quiet_ff == '1) ? quiet_ff : quiet_ff + 1'b1;
      take       = (level != prev_ff) && (quiet_inc > debounce);
      prev_in    = prev_ff;
      armed_in   = armed_ff;
      pending_in = pending_ff;
      quiet_in   = quiet_ff;
      if (tick) begin
         prev_in  = level;
         quiet_in = take ? '0 : quiet_inc;
         if (take) begin
            // low arms, high after arming latches the event
            if (!level && !armed_ff) begin
               armed_in = 1'b1;
            end else if (level && armed_ff) begin
               armed_in   = 1'b0;
               pending_in = 1'b1;
            end
         end
      end else if (clear) begin
         pending_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff    <= 1'b1;
         armed_ff   <= 1'b0;
         pending_ff <= 1'b0;
         quiet_ff   <= '1;
      end else begin
         prev_ff    <= prev_in;
         armed_ff   <= armed_in;
         pending_ff <= pending_in;
         quiet_ff   <= quiet_in;
      end
   end

   assign pending = pending_ff;

endmodule
`default_nettype wire

// ===== rtl/delpr_button_lane.sv =====
`default_nettype none
module delpr_button_lane
   import delpr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  tick,
   input  wire logic                  reading,
   input  wire logic [BUTTON_Q_W-1:0] debounce,
   input  wire logic                  clear,
   output logic                       pending
);

   logic                  last_ff, last_in;
   logic                  stable_ff, stable_in;
   logic                  pending_ff, pending_in;
   logic [BUTTON_Q_W-1:0] quiet_ff, quiet_in;
   logic [BUTTON_Q_W-1:0] quiet_new;

   always_comb begin
      if (reading != last_ff) begin
         quiet_new = '0;
      end else begin
         quiet_new = (quiet_ff == '1) ? quiet_ff : quiet_ff + 1'b1;
      end
      last_in    = last_ff;
      stable_in  = stable_ff;
      pending_in = pending_ff;
      quiet_in   = quiet_ff;
      if (tick) begin
         last_in  = reading;
         quiet_in = quiet_new;
         if ((quiet_new > debounce) && (reading != stable_ff)) begin
            stable_in = reading;
            // latch on a settled press only
            if (!reading) begin
               pending_in = 1'b1;
            end
         end
      end else if (clear) begin
         pending_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff    <= 1'b1;
         stable_ff  <= 1'b1;
         pending_ff <= 1'b0;
         quiet_ff   <= '1;
      end else begin
         last_ff    <= last_in;
         stable_ff  <= stable_in;
         pending_ff <= pending_in;
         quiet_ff   <= quiet_in;
      end
   end

   assign pending = pending_ff;

endmodule
`default_nettype wire

// ===== rtl/delpr_merge.sv =====
`default_nettype none
module delpr_merge
   import delpr_pkg::*;
#(
   parameter int SENSOR_CHANNELS = SENSOR_CHANNELS_DEF,
   parameter int BUTTON_CHANNELS = BUTTON_CHANNELS_DEF
) (
   input  wire logic [SENSOR_CHANNELS-1:0] sensor_pending,
   input  wire logic [BUTTON_CHANNELS-1:0] button_pending,
   output logic [SENSOR_CHANNELS-1:0]      sensor_grant,
   output logic [BUTTON_CHANNELS-1:0]      button_grant,
   output pick_type                        pick
);

   logic sensor_any;
   logic button_any;

   always_comb begin
      sensor_any = |sensor_pending;
      button_any = |button_pending;
      // lowest set bit wins
      sensor_grant = sensor_pending & ~(sensor_pending - 1'b1);
      button_grant = sensor_any ? '0 : (button_pending & ~(button_pending - 1'b1));

      pick.hit = sensor_any || button_any;
      pick.pin = NO_PIN;
      for (int i = BUTTON_CHANNELS - 1; i >= 0; i--) begin
         if (button_pending[i]) begin
            pick.pin = BUTTON_PIN_TABLE[i];
         end
      end
      for (int i = SENSOR_CHANNELS - 1; i >= 0; i--) begin
         if (sensor_pending[i]) begin
            pick.pin = SENSOR_PIN_TABLE[i];
         end
      end
   end

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
   import delpr_pkg::*;

   localparam int SC = SENSOR_CHANNELS_DEF;
   localparam int BC = BUTTON_CHANNELS_DEF;
   localparam int unsigned SENSOR_QUIET_MAX = (1 << SENSOR_Q_W) - 1;
   localparam int unsigned BUTTON_QUIET_MAX = (1 << BUTTON_Q_W) - 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_INDEX = 2'd3;
   localparam int unsigned SETTLE_CYCLES = 6;
   localparam int unsigned WATCHDOG_LIMIT = 4000;
   localparam int unsigned PHASE_ITEMS = 191;
   localparam int unsigned LONG_HOLD = 60;

   typedef struct {
      pin_type pin;
      logic    pin_state;
   } pin_report_type;

   class latch_scoreboard;
      logic [SENSOR_Q_W-1:0] sensor_gap;
      logic [BUTTON_Q_W-1:0] button_hold;
      bit          s_level[SC];
      bit          s_armed[SC];
      bit          s_pending[SC];
      int unsigned s_quiet[SC];
      bit          b_reading[BC];
      bit          b_stable[BC];
      bit          b_pending[BC];
      int unsigned b_quiet[BC];
      pin_report_type due_reports[$];
      int unsigned mismatches;

      function new();
         sensor_gap  = SENSOR_DEBOUNCE_RST;
         button_hold = BUTTON_DEBOUNCE_RST;
         mismatches  = 0;
         for (int i = 0; i < SC; i++) begin
            s_level[i]   = 1'b1;
            s_armed[i]   = 1'b0;
            s_pending[i] = 1'b0;
            s_quiet[i]   = SENSOR_QUIET_MAX;
         end
         for (int i = 0; i < BC; i++) begin
            b_reading[i] = 1'b1;
            b_stable[i]  = 1'b1;
            b_pending[i] = 1'b0;
            b_quiet[i]   = BUTTON_QUIET_MAX;
         end
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_SENSOR_DEBOUNCE: sensor_gap = data[SENSOR_Q_W-1:0];
            CSR_BUTTON_DEBOUNCE: button_hold = data[BUTTON_Q_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_beat(logic act, logic [SC-1:0] s, logic [BC-1:0] b);
         pin_report_type r;
         bit             lv;
         bit             found;
         if (act == ACTION_TICK) begin
            for (int i = 0; i < SC; i++) begin
               lv = s[i];
               if (s_quiet[i] < SENSOR_QUIET_MAX) s_quiet[i]++;
               if (lv != s_level[i] && s_quiet[i] > sensor_gap) begin
                  if (!lv && !s_armed[i]) begin
                     s_armed[i] = 1'b1;
                  end else if (lv && s_armed[i]) begin
                     s_pending[i] = 1'b1;
                     s_armed[i]   = 1'b0;
                  end
                  // clear even when the change had no effect
                  s_quiet[i] = 0;
               end
               s_level[i] = lv;
            end
            for (int i = 0; i < BC; i++) begin
               lv = b[i];
               if (lv != b_reading[i]) b_quiet[i] = 0;
               else if (b_quiet[i] < BUTTON_QUIET_MAX) b_quiet[i]++;
               if (b_quiet[i] > button_hold && lv != b_stable[i]) begin
                  b_stable[i] = lv;
                  if (!lv) b_pending[i] = 1'b1;
               end
               b_reading[i] = lv;
            end
            return;
         end
         r.pin       = NO_PIN;
         r.pin_state = 1'b0;
         found       = 1'b0;
         for (int i = 0; i < SC; i++) begin
            if (!found && s_pending[i]) begin
               s_pending[i] = 1'b0;
               r.pin        = SENSOR_PIN_TABLE[i];
               r.pin_state  = 1'b1;
               found        = 1'b1;
            end
         end
         for (int i = 0; i < BC; i++) begin
            if (!found && b_pending[i]) begin
               b_pending[i] = 1'b0;
               r.pin        = BUTTON_PIN_TABLE[i];
               r.pin_state  = 1'b1;
               found        = 1'b1;
            end
         end
         due_reports.push_back(r);
      endfunction

      function void check_report(pin_type pin, logic st);
         pin_report_type r;
         if (due_reports.size() == 0) begin
            $display("%0t unexpected response: pin_number %0d pin_state %0d", $time, pin, st);
            mismatches++;
            return;
         end
         r = due_reports.pop_front();
         if (pin !== r.pin) begin
            $display("%0t pin_number mismatch: expected %0d, got %0d", $time, r.pin, pin);
            mismatches++;
         end
         if (st !== r.pin_state) begin
            $display("%0t pin_state mismatch: expected %0d, got %0d", $time, r.pin_state, st);
            mismatches++;
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_action = ACTION_TICK;
   logic [SC-1:0]          req_sensor_levels = '1;
   logic [BC-1:0]          req_button_levels = '1;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [PIN_W-1:0]       rsp_pin_number;
   logic                   rsp_pin_state;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_SENSOR_DEBOUNCE;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   latch_scoreboard scoreboard = new();
   int unsigned     send_idle_pct = 0;
   int unsigned     stall_pct = 0;
   int unsigned     quiet_cycles = 0;
   logic [SC-1:0]   cur_sensors = '1;
   logic [BC-1:0]   cur_buttons = '1;

   debounced_event_latch_priority_read_core DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_sensor_levels (req_sensor_levels),
      .req_button_levels (req_button_levels),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pin_number    (rsp_pin_number),
      .rsp_pin_state     (rsp_pin_state),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #1 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall = ($urandom_range(99) < stall_pct);
   end

   // monitor and watchdog: sample every handshake at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (rsp_valid && !rsp_stall) scoreboard.check_report(rsp_pin_number, rsp_pin_state);
         if (req_valid && !req_stall)
            scoreboard.note_beat(req_action, req_sensor_levels, req_button_levels);
         if (csr_valid && csr_ready) scoreboard.write_register(csr_index, csr_data);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
               $display("[debounced_event_latch_priority_read_core] ERROR");
               $finish;
            end
         end
      end
   end

   // entered and left at a falling edge; valid stays high into the next beat
   task automatic put_beat(logic act, logic [SC-1:0] s, logic [BC-1:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid         = 1'b1;
      req_action        = act;
      req_sensor_levels = s;
      req_button_levels = b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic quiesce();
      req_valid = 1'b0;
      while (scoreboard.due_reports.size() != 0) @(negedge clock);
      // ticks give no response, so allow the last one to finish
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic int unsigned settle_ticks();
      int unsigned n;
      n = 1;
      if (scoreboard.sensor_gap < LONG_HOLD) n = scoreboard.sensor_gap + 1;
      if (scoreboard.button_hold < LONG_HOLD && scoreboard.button_hold + 2 > n)
         n = scoreboard.button_hold + 2;
      return n;
   endfunction

   // hold most level sets long enough to pass a debounce below LONG_HOLD, with short glitches mixed in
   task automatic run_phase(int unsigned items);
      int unsigned   sent;
      int unsigned   hold;
      logic [SC-1:0] flip_s;
      logic [BC-1:0] flip_b;
      sent = 0;
      while (sent < items) begin
         flip_s = SC'($urandom);
         flip_b = BC'($urandom);
         if ($urandom_range(1)) flip_s &= SC'($urandom & $urandom);
         if ($urandom_range(1)) flip_b &= BC'($urandom);
         cur_sensors ^= flip_s;
         cur_buttons ^= flip_b;
         if ($urandom_range(9) < 7) hold = settle_ticks() + $urandom_range(2);
         else hold = $urandom_range(1, 2);
         if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(3, 8)) begin
               put_beat(ACTION_READ, SC'($urandom), BC'($urandom));
               sent++;
            end
         end
         for (int unsigned k = 0; k < hold && sent < items; k++) begin
            if ($urandom_range(4) == 0) begin
               put_beat(ACTION_READ, SC'($urandom), BC'($urandom));
               sent++;
            end
            put_beat(ACTION_TICK, cur_sensors, cur_buttons);
            sent++;
         end
      end
   endtask

   initial begin
      int unsigned sensor_gaps[8];
      int unsigned button_holds[8];
      sensor_gaps  = '{0, 65534, 2, 0, 1, 0, 65534, 50};
      button_holds = '{0, 1048574, 5, 0, 0, 1048574, 0, 3};
      sensor_gaps[3]  = $urandom_range(6);
      button_holds[3] = $urandom_range(10);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset debounce values: a sensor's first change from the reset level is taken at once
      put_beat(ACTION_READ, '0, '0);
      put_beat(ACTION_TICK, '1, '1);
      put_beat(ACTION_TICK, '0, '0);
      put_beat(ACTION_READ, '1, '1);
      quiesce();
      write_register(CSR_SENSOR_DEBOUNCE, '0);
      write_register(CSR_BUTTON_DEBOUNCE, '0);
      write_register(CSR_SPARE_INDEX, '1);
      // latch every channel, then drain them in priority order and one more
      put_beat(ACTION_TICK, '1, '0);
      for (int i = 0; i < SC + BC + 1; i++) begin
         if (i % 2 == 0) put_beat(ACTION_READ, '1, '1);
         else put_beat(ACTION_READ, '0, '0);
      end

      for (int p = 0; p < 8; p++) begin
         quiesce();
         write_register(CSR_SENSOR_DEBOUNCE, CSR_DATA_W'(sensor_gaps[p]));
         write_register(CSR_BUTTON_DEBOUNCE, CSR_DATA_W'(button_holds[p]));
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 64; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 64; end
            default: begin send_idle_pct = 20; stall_pct = 20; end
         endcase
         run_phase(PHASE_ITEMS);
      end
      quiesce();

      if (scoreboard.mismatches == 0 && scoreboard.due_reports.size() == 0) begin
         $display("[debounced_event_latch_priority_read_core] OK");
      end else begin
         $display("[debounced_event_latch_priority_read_core] ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire
